// ----- src/ppi_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package ppi_pkg;
  localparam int COORD_FRAC_BITS = 16;
  localparam logic [30:0] DIST_RESET = 31'(((3 << COORD_FRAC_BITS) + 5) / 10);

  typedef enum logic [1:0] {
    ACT_LAUNCH = 2'd0,
    ACT_TICK   = 2'd1,
    ACT_STOP   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_NONE    = 2'd0,
    ST_FLYING  = 2'd1,
    ST_SUCCESS = 2'd2,
    ST_FAILURE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    REG_STEP_LENGTH = 3'd0,
    REG_HIT_RADIUS  = 3'd1,
    REG_LAUNCH_X    = 3'd2,
    REG_LAUNCH_Y    = 3'd3,
    REG_LAUNCH_Z    = 3'd4
  } reg_index_t;

  localparam int NUM_W  = 64;
  localparam int DEN_W  = 33;
  localparam int QUO_W  = 32;
  localparam int DIV_CW = $clog2(NUM_W);
endpackage
`default_nettype wire

// ----- src/ppi_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface ppi_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [31:0] target_x;
  logic signed [31:0] target_y;
  logic signed [31:0] target_z;
  logic               target_detonated;
  logic [15:0]        target_id;
  modport source (output valid, action, target_x, target_y, target_z, target_detonated,
                  target_id, input ready);
  modport sink (input valid, action, target_x, target_y, target_z, target_detonated,
                target_id, output ready);
endinterface

interface ppi_res_if;
  logic               valid;
  logic               ready;
  logic [1:0]         pursuer_status;
  logic signed [31:0] pursuer_x;
  logic signed [31:0] pursuer_y;
  logic signed [31:0] pursuer_z;
  logic               intercept_report;
  logic [15:0]        reported_target;
  modport source (output valid, pursuer_status, pursuer_x, pursuer_y, pursuer_z,
                  intercept_report, reported_target, input ready);
  modport sink (input valid, pursuer_status, pursuer_x, pursuer_y, pursuer_z,
                intercept_report, reported_target, output ready);
endinterface

interface ppi_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- src/ppi_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ppi_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [ppi_pkg::NUM_W-1:0] num,
  input  wire logic [ppi_pkg::DEN_W-1:0] den,
  output logic                           done,
  output logic [ppi_pkg::QUO_W-1:0]      quo
);
  logic                           busy;
  logic [ppi_pkg::DIV_CW-1:0]     cnt;
  logic [ppi_pkg::NUM_W-1:0]      nsh;
  logic [ppi_pkg::DEN_W-1:0]      dv;
  logic [ppi_pkg::DEN_W-1:0]      rem;
  logic [ppi_pkg::DEN_W:0]        rem_sh;
  logic                           fit;

  assign rem_sh = {rem, nsh[ppi_pkg::NUM_W-1]};
  assign fit    = rem_sh >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        nsh  <= num;
        dv   <= den;
        rem  <= '0;
        quo  <= '0;
      end else if (busy) begin
        nsh <= {nsh[ppi_pkg::NUM_W-2:0], 1'b0};
        rem <= fit ? ppi_pkg::DEN_W'(rem_sh - {1'b0, dv}) : rem_sh[ppi_pkg::DEN_W-1:0];
        quo <= {quo[ppi_pkg::QUO_W-2:0], fit};
        cnt <= cnt + 1'b1;
        if (cnt == ppi_pkg::DIV_CW'(ppi_pkg::NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- src/point_pursuit_intercept.sv -----
`timescale 1ns / 1ps
`default_nettype none
// channel | dir | payload
// cfg     | in  | index, data (register write)
// cmd     | in  | action, target_x/y/z, target_detonated, target_id
// res     | out | pursuer_status, pursuer_x/y/z, intercept_report, reported_target
// Launch loads the launch position and returns no result; stop and detonated
// ticks go straight to emit. A moving tick runs bit-serial squaring of each
// axis difference, a square root and a decision, then, if it moves, a serial
// multiply and divide per axis. rst clears control, position and configuration.
// A held result keeps the block in its emit state and holds off the next request.
module point_pursuit_intercept (
  input wire logic clk,
  input wire logic rst,
  ppi_cfg_if.sink  cfg,
  ppi_cmd_if.sink  cmd,
  ppi_res_if.source res
);
  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_SQ, S_SQACC, S_ROOT, S_DECIDE, S_MUL, S_DIVST, S_DIVW, S_EMIT
  } state_t;

  state_t state;
  logic [30:0]        step_length;
  logic [30:0]        hit_radius;
  logic [31:0]        launch [0:2];
  logic [31:0]        pos [0:2];
  logic               flying;
  logic [31:0]        tgt [0:2];
  logic [15:0]        tid;
  logic [32:0]        mag [0:2];
  logic               neg [0:2];
  logic [1:0]         axis;
  logic [5:0]         cnt;
  logic [32:0]        mr;
  logic [30:0]        mv;
  logic [30:0]        move;
  logic [65:0]        prod;
  logic [65:0]        sum;
  logic [65:0]        rad;
  logic [35:0]        rem;
  logic [32:0]        root;
  logic [1:0]         status;
  logic               report;
  logic               ovalid;
  logic               div_start;
  logic               div_done;
  logic [31:0]        quo;
  logic [63:0]        num;
  logic [35:0]        rem_sh;
  logic [35:0]        trial;
  logic [65:0]        sum_add;
  logic [32:0]        cur_mag;

  assign cfg.ready = 1'b1;
  assign cmd.ready = state == S_IDLE;
  assign res.valid = ovalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_length <= ppi_pkg::DIST_RESET;
      hit_radius  <= ppi_pkg::DIST_RESET;
      launch[0]   <= '0;
      launch[1]   <= '0;
      launch[2]   <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        ppi_pkg::REG_STEP_LENGTH: step_length <= cfg.data[30:0];
        ppi_pkg::REG_HIT_RADIUS:  hit_radius  <= cfg.data[30:0];
        ppi_pkg::REG_LAUNCH_X:    launch[0]   <= cfg.data;
        ppi_pkg::REG_LAUNCH_Y:    launch[1]   <= cfg.data;
        ppi_pkg::REG_LAUNCH_Z:    launch[2]   <= cfg.data;
        default: ;
      endcase
    end
  end

  assign cur_mag = mag[axis];
  assign rem_sh  = {rem[33:0], rad[65:64]};
  assign trial   = {1'b0, root[32:0], 2'b01};
  assign sum_add = sum + prod;
  assign num     = prod[63:0] + {31'd0, root[32:1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      flying    <= 1'b0;
      ovalid    <= 1'b0;
      div_start <= 1'b0;
      pos[0]    <= '0;
      pos[1]    <= '0;
      pos[2]    <= '0;
    end else begin
      div_start <= 1'b0;
      if (ovalid && res.ready && state != S_EMIT) ovalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            tgt[0] <= cmd.target_x;
            tgt[1] <= cmd.target_y;
            tgt[2] <= cmd.target_z;
            tid    <= cmd.target_id;
            report <= 1'b0;
            case (cmd.action)
              ppi_pkg::ACT_LAUNCH: begin
                pos[0] <= launch[0];
                pos[1] <= launch[1];
                pos[2] <= launch[2];
                flying <= 1'b1;
              end
              ppi_pkg::ACT_STOP: begin
                if (flying) begin
                  flying <= 1'b0;
                  status <= ppi_pkg::ST_FAILURE;
                  state  <= S_EMIT;
                end
              end
              ppi_pkg::ACT_TICK: begin
                if (flying) begin
                  if (cmd.target_detonated) begin
                    flying <= 1'b0;
                    status <= ppi_pkg::ST_FAILURE;
                    state  <= S_EMIT;
                  end else begin
                    state <= S_DIFF;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_DIFF: begin
          for (int i = 0; i < 3; i++) begin
            logic [32:0] d;
            d = {tgt[i][31], tgt[i]} - {pos[i][31], pos[i]};
            neg[i] <= d[32];
            mag[i] <= d[32] ? 33'(-d) : d;
            if (i == 0) mr <= d[32] ? 33'(-d) : d;
          end
          sum   <= '0;
          prod  <= '0;
          axis  <= '0;
          cnt   <= '0;
          state <= S_SQ;
        end
        S_SQ: begin
          prod <= {prod[64:0], 1'b0} + (mr[32] ? {33'd0, cur_mag} : 66'd0);
          mr   <= {mr[31:0], 1'b0};
          cnt  <= cnt + 1'b1;
          if (cnt == 6'd32) state <= S_SQACC;
        end
        S_SQACC: begin
          sum  <= sum_add;
          prod <= '0;
          cnt  <= '0;
          if (axis == 2'd2) begin
            rad   <= sum_add;
            rem   <= '0;
            root  <= '0;
            state <= S_ROOT;
          end else begin
            mr    <= mag[axis + 2'd1];
            axis  <= axis + 2'd1;
            state <= S_SQ;
          end
        end
        S_ROOT: begin
          rad <= {rad[63:0], 2'b00};
          if (rem_sh >= trial) begin
            rem  <= rem_sh - trial;
            root <= {root[31:0], 1'b1};
          end else begin
            rem  <= rem_sh;
            root <= {root[31:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == 6'd32) state <= S_DECIDE;
        end
        S_DECIDE: begin
          axis <= '0;
          cnt  <= '0;
          prod <= '0;
          if (root < {2'b00, hit_radius}) begin
            flying <= 1'b0;
            status <= ppi_pkg::ST_SUCCESS;
            report <= 1'b1;
            state  <= S_EMIT;
          end else if (root == '0) begin
            status <= ppi_pkg::ST_FLYING;
            state  <= S_EMIT;
          end else begin
            move  <= ({2'b00, step_length} < root) ? step_length : root[30:0];
            mv    <= ({2'b00, step_length} < root) ? step_length : root[30:0];
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod <= {prod[64:0], 1'b0} + (mv[30] ? {33'd0, cur_mag} : 66'd0);
          mv   <= {mv[29:0], 1'b0};
          cnt  <= cnt + 1'b1;
          if (cnt == 6'd30) state <= S_DIVST;
        end
        S_DIVST: begin
          div_start <= 1'b1;
          state     <= S_DIVW;
        end
        S_DIVW: begin
          if (div_done) begin
            pos[axis] <= neg[axis] ? pos[axis] - quo : pos[axis] + quo;
            prod      <= '0;
            cnt       <= '0;
            mv        <= move;
            if (axis == 2'd2) begin
              status <= ppi_pkg::ST_FLYING;
              state  <= S_EMIT;
            end else begin
              axis  <= axis + 2'd1;
              state <= S_MUL;
            end
          end
        end
        S_EMIT: begin
          if (!ovalid || res.ready) begin
            ovalid               <= 1'b1;
            res.pursuer_status   <= status;
            res.pursuer_x        <= pos[0];
            res.pursuer_y        <= pos[1];
            res.pursuer_z        <= pos[2];
            res.intercept_report <= report;
            res.reported_target  <= report ? tid : 16'd0;
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  ppi_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (root),
    .done  (div_done),
    .quo   (quo)
  );
endmodule
`default_nettype wire
